// File: hw/rtl/least_connections_backend_selector_macros.svh
// Assertion macros for the backend selector.
// Each macro expects clk and arst_n in scope.
`ifndef LEAST_CONNECTIONS_BACKEND_SELECTOR_MACROS_SVH
`define LEAST_CONNECTIONS_BACKEND_SELECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LCBS_ASSERT_IMP(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
`define LCBS_ASSERT_NXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define LCBS_ASSERT_IMP(label, a, b, msg)
`define LCBS_ASSERT_NXT(label, a, b, msg)
`endif
`endif

// File: hw/rtl/lcbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbs_pkg
// Shared types and constants of the least-connections backend selector.
// ----------------------------------------------------------------------------
package lcbs_pkg;
	localparam int DVD_W = 32;
	localparam int ROT_W = 32;
	localparam int CNT_W = 16;
	localparam int STK_W = 8;
	localparam int AVG_W = 20;
	localparam int LAT_W = 20;
	localparam int IDX_W = 6;

	localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [STK_W-1:0] STREAK_MAX = '1;

	// average*9 + sample never reaches 2**25
	localparam int SUM_W  = 25;
	localparam int RCP_W  = 25;
	localparam int RCP_SH = 28;
	// x / 10 == (x * RCP_10) >> RCP_SH for any x below 2**26
	localparam logic [RCP_W-1:0] RCP_10 = 25'd26843546;

	localparam logic [1:0] OP_PICK   = 2'd0;
	localparam logic [1:0] OP_DONE   = 2'd1;
	localparam logic [1:0] OP_HEALTH = 2'd2;
	localparam logic [1:0] OP_RSVD   = 2'd3;

	localparam logic [1:0] REG_BACKEND_COUNT = 2'd0;
	localparam logic [1:0] REG_RISE          = 2'd1;
	localparam logic [1:0] REG_FALL          = 2'd2;

	typedef struct packed {
		logic             alive;
		logic [CNT_W-1:0] cnt;
		logic [STK_W-1:0] succ;
		logic [STK_W-1:0] fail;
		logic [AVG_W-1:0] avg;
	} ent_t;
endpackage

// File: hw/rtl/lcbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbs_div
// Restoring divider giving the remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcbs_div import lcbs_pkg::*; #(
	parameter int VW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [VW-1:0]    divisor,
	output logic             done,
	output logic [VW-1:0]    rem
);
	localparam int SW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    d_q;
	logic [SW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      sh;
	logic             ge;

	assign sh = {rem_q, quo_q[DVD_W-1]};
	assign ge = sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? VW'(sh - {1'b0, d_q}) : VW'(sh);
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// File: hw/rtl/least_connections_backend_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_connections_backend_selector
// Least-connections pick with round-robin tie break, completion and health.
// ----------------------------------------------------------------------------
// A pick scans the table, divides for a tied least count, scans again and
// writes the picked count back, or ends after one scan with no backend alive.
// Completion and health read, load and write back the entry, dividing by ten
// for an average update; index out of range or unused op goes to the output.
// One request at a time; a result still waiting on m_tready holds the next one back.
// Reset (arst_n low) empties the table via per-entry valid bits, at once.
module least_connections_backend_selector import lcbs_pkg::*; #(
	parameter int MAX_BACKENDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [5:0] backend, [6] healthy, [7] forward_ok, [27:8] latency_ms
	input  logic [31:0] s_tdata,
	// [1:0] op
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] found, [6:1] backend_index, [22:7] conn_cnt, [42:23] average_ms,
	// [43] alive, [44] alive_changed
	output logic [47:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);
	`include "least_connections_backend_selector_macros.svh"

	localparam int IW    = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
	localparam int CW    = IW + 1;
	localparam int TIE_W = $clog2(MAX_BACKENDS + 1);
	localparam int DVW   = (TIE_W < 4) ? 4 : TIE_W;
	localparam int PRD_W = SUM_W + RCP_W;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SCAN1 = 9'b000000010,
		ST_DIVK  = 9'b000000100,
		ST_SCAN2 = 9'b000001000,
		ST_RD    = 9'b000010000,
		ST_LOAD  = 9'b000100000,
		ST_DIVA  = 9'b001000000,
		ST_WB    = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [6:0] bc_q;
	logic [7:0] rise_q, fall_q;
	logic [CW-1:0] n_eff;

	// table
	ent_t mem [MAX_BACKENDS];
	logic [MAX_BACKENDS-1:0] vld_q;
	ent_t rd_data_q;
	logic rd_vld_q;
	ent_t rd_ent;
	logic [IW-1:0] rd_addr;

	logic [1:0] op_q;
	logic healthy_q, ok_q;
	logic [LAT_W-1:0] lat_q;
	logic [IDX_W-1:0] idx_q;
	logic [IW-1:0] addr_q;

	logic [CW-1:0] scan_q;
	logic iss_s1;
	logic [IW-1:0] sidx_s1;
	logic scan_end;

	logic any_q, picked_q;
	logic [CNT_W-1:0] best_q;
	logic [TIE_W-1:0] ties_q, k_q;
	logic [ROT_W-1:0] rot_q;

	ent_t ent_q, upd;
	logic found_q, chg_q, upd_chg;

	logic [SUM_W-1:0] sum_q;
	logic [PRD_W-1:0] avg_prod;

	logic div_start, div_done;
	logic [DVW-1:0] div_dvs, div_rem;

	logic [5:0] in_idx;
	assign in_idx = s_tdata[5:0];

	assign n_eff = (32'(bc_q) > 32'(MAX_BACKENDS)) ? CW'(MAX_BACKENDS) : CW'(bc_q);
	assign s_tready = (state_q == ST_IDLE);
	assign rd_addr = (state_q == ST_SCAN1 || state_q == ST_SCAN2) ? scan_q[IW-1:0] : addr_q;
	assign rd_ent = rd_vld_q ? rd_data_q : '0;
	assign scan_end = (scan_q >= n_eff) && !iss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q   <= 7'd5;
			rise_q <= 8'd2;
			fall_q <= 8'd2;
		end else if (cfg_we) begin
			priority case (cfg_addr)
				REG_BACKEND_COUNT: bc_q   <= cfg_wdata[6:0];
				REG_RISE:          rise_q <= cfg_wdata;
				REG_FALL:          fall_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// memory: one read, one write
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (state_q == ST_WB)
			mem[addr_q] <= ent_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (state_q == ST_WB)
				vld_q[addr_q] <= 1'b1;
		end
	end

	// completion / health update of the loaded entry
	always_comb begin
		upd = rd_ent;
		upd_chg = 1'b0;
		if (op_q == OP_DONE) begin
			if (rd_ent.cnt != '0)
				upd.cnt = rd_ent.cnt - 1'b1;
			if (ok_q && rd_ent.avg == '0)
				upd.avg = lat_q;
		end else if (healthy_q) begin
			upd.fail = '0;
			if (rd_ent.succ != STREAK_MAX)
				upd.succ = rd_ent.succ + 1'b1;
			if (upd.succ >= rise_q && !rd_ent.alive) begin
				upd.alive = 1'b1;
				upd_chg = 1'b1;
			end
		end else begin
			upd.succ = '0;
			if (rd_ent.fail != STREAK_MAX)
				upd.fail = rd_ent.fail + 1'b1;
			if (upd.fail >= fall_q && rd_ent.alive) begin
				upd.alive = 1'b0;
				upd_chg = 1'b1;
			end
		end
	end

	// divide by ten as a reciprocal multiply
	assign avg_prod = PRD_W'(sum_q) * PRD_W'(RCP_10);

	assign div_start = (state_q == ST_SCAN1) && scan_end && any_q && (ties_q > TIE_W'(1));
	assign div_dvs = DVW'(ties_q);

	lcbs_div #(.VW(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rot_q),
		.divisor  (div_dvs),
		.done     (div_done),
		.rem      (div_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rot_q    <= '0;
			iss_s1   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_OUT)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						scan_q <= '0;
						iss_s1 <= 1'b0;
						any_q <= 1'b0;
						picked_q <= 1'b0;
						ent_q <= '0;
						found_q <= 1'b0;
						chg_q <= 1'b0;
						if (s_tuser == OP_PICK) begin
							idx_q <= '0;
							state_q <= ST_SCAN1;
						end else begin
							idx_q <= in_idx;
							addr_q <= IW'(in_idx);
							if (s_tuser != OP_DONE && s_tuser != OP_HEALTH)
								state_q <= ST_OUT;
							else if (32'(in_idx) >= 32'(n_eff))
								state_q <= ST_OUT;
							else
								state_q <= ST_RD;
						end
					end
				end
				ST_SCAN1, ST_SCAN2: begin
					if (scan_q < n_eff) begin
						scan_q <= scan_q + 1'b1;
						iss_s1 <= 1'b1;
					end else begin
						iss_s1 <= 1'b0;
					end
					sidx_s1 <= scan_q[IW-1:0];
					if (state_q == ST_SCAN1) begin
						if (iss_s1 && rd_ent.alive) begin
							if (!any_q || rd_ent.cnt < best_q) begin
								best_q <= rd_ent.cnt;
								ties_q <= TIE_W'(1);
								any_q <= 1'b1;
							end else if (rd_ent.cnt == best_q) begin
								ties_q <= ties_q + 1'b1;
							end
						end
						if (scan_end) begin
							scan_q <= '0;
							iss_s1 <= 1'b0;
							if (!any_q) begin
								state_q <= ST_OUT;
							end else if (ties_q > TIE_W'(1)) begin
								rot_q <= rot_q + 1'b1;
								state_q <= ST_DIVK;
							end else begin
								k_q <= '0;
								state_q <= ST_SCAN2;
							end
						end
					end else begin
						if (iss_s1 && rd_ent.alive && rd_ent.cnt == best_q && !picked_q) begin
							if (k_q == '0) begin
								picked_q <= 1'b1;
								addr_q <= sidx_s1;
								idx_q <= IDX_W'(sidx_s1);
								ent_q <= rd_ent;
								if (rd_ent.cnt != COUNT_MAX)
									ent_q.cnt <= rd_ent.cnt + 1'b1;
							end else begin
								k_q <= k_q - 1'b1;
							end
						end
						if (scan_end) begin
							found_q <= 1'b1;
							state_q <= ST_WB;
						end
					end
				end
				ST_DIVK: begin
					if (div_done) begin
						k_q <= TIE_W'(div_rem);
						state_q <= ST_SCAN2;
					end
				end
				ST_RD:
					state_q <= ST_LOAD;
				ST_LOAD: begin
					ent_q <= upd;
					chg_q <= upd_chg;
					sum_q <= (SUM_W'(rd_ent.avg) << 3) + SUM_W'(rd_ent.avg) + SUM_W'(lat_q);
					if (op_q == OP_DONE && ok_q && rd_ent.avg != '0)
						state_q <= ST_DIVA;
					else
						state_q <= ST_WB;
				end
				ST_DIVA: begin
					ent_q.avg <= avg_prod[RCP_SH +: AVG_W];
					state_q <= ST_WB;
				end
				ST_WB:
					state_q <= ST_OUT;
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata <= {3'b0, chg_q, ent_q.alive, ent_q.avg, ent_q.cnt, idx_q,
							found_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the request fields
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q <= s_tuser;
			healthy_q <= s_tdata[6];
			ok_q <= s_tdata[7];
			lat_q <= s_tdata[27:8];
		end
	end

	`LCBS_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready after request")
	`LCBS_ASSERT_IMP(a_found_alive, m_tvalid && m_tdata[0], m_tdata[43], "found but not alive")
	`LCBS_ASSERT_IMP(a_chg_not_pick, m_tvalid && m_tdata[44], !m_tdata[0], "change on a pick")
	`LCBS_ASSERT_IMP(a_div_state, div_done, state_q == ST_DIVK, "divider done outside its wait")
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the least-connections backend selector. A
// scoreboard class keeps its own copy of the backend table, predicts each
// result from the requests taken by the block and checks the results
// in order. A directed opening is followed by random phases that change the
// configuration and the idling of both stream sides.
// ----------------------------------------------------------------------------
import lcbs_pkg::*;

class backend_scoreboard;
	bit [6:0]       cfg_count;
	bit [7:0]       cfg_rise;
	bit [7:0]       cfg_fall;
	bit             alive_tbl [64];
	bit [CNT_W-1:0] count_tbl [64];
	bit [STK_W-1:0] succ_tbl  [64];
	bit [STK_W-1:0] fail_tbl  [64];
	bit [AVG_W-1:0] avg_tbl   [64];
	bit [ROT_W-1:0] rotation;
	bit [47:0]      pending [$];
	int             errors;

	function new();
		cfg_count = 5;
		cfg_rise  = 2;
		cfg_fall  = 2;
		for (int i = 0; i < 64; i++) begin
			alive_tbl[i] = 0;
			count_tbl[i] = 0;
			succ_tbl[i]  = 0;
			fail_tbl[i]  = 0;
			avg_tbl[i]   = 0;
		end
		rotation = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [1:0] addr, logic [7:0] val);
		case (addr)
			REG_BACKEND_COUNT: cfg_count = val[6:0];
			REG_RISE:          cfg_rise  = val;
			REG_FALL:          cfg_fall  = val;
			default: ;
		endcase
	endfunction

	function int entries();
		return (cfg_count > 64) ? 64 : int'(cfg_count);
	endfunction

	function void push(bit found, bit [5:0] idx, bit [15:0] cnt, bit [19:0] avg,
			bit alv, bit chg);
		bit [47:0] item;
		item = {3'b0, chg, alv, avg, cnt, idx, found};
		pending = {pending, item};
	endfunction

	// predict the result of one accepted request
	function void note_request(logic [1:0] op, logic [31:0] data);
		bit [5:0]  idx;
		bit [19:0] lat;
		bit [15:0] best;
		bit [31:0] ties, k;
		bit [63:0] nv;
		bit        any, chg;
		int        n, pick;
		idx = data[5:0];
		lat = data[27:8];
		n = entries();
		if (op == OP_PICK) begin
			any = 0;
			best = 0;
			ties = 0;
			for (int i = 0; i < n; i++) begin
				if (!alive_tbl[i]) continue;
				if (!any || count_tbl[i] < best) begin
					best = count_tbl[i];
					ties = 1;
					any = 1;
				end else if (count_tbl[i] == best) begin
					ties++;
				end
			end
			if (!any) begin
				push(0, 0, 0, 0, 0, 0);
				return;
			end
			if (ties > 1) begin
				k = rotation % ties;
				rotation = rotation + 1;
			end else begin
				k = 0;
			end
			pick = 0;
			for (int i = 0; i < n; i++) begin
				if (alive_tbl[i] && count_tbl[i] == best) begin
					if (k == 0) begin
						pick = i;
						break;
					end
					k--;
				end
			end
			if (count_tbl[pick] != COUNT_MAX) count_tbl[pick]++;
			push(1, pick[5:0], count_tbl[pick], avg_tbl[pick], 1, 0);
			return;
		end
		if (op == OP_RSVD || idx >= n) begin
			push(0, idx, 0, 0, 0, 0);
			return;
		end
		if (op == OP_DONE) begin
			if (count_tbl[idx] != 0) count_tbl[idx]--;
			if (data[7]) begin
				nv = (avg_tbl[idx] == 0) ? 64'(lat) : (64'(avg_tbl[idx]) * 9 + 64'(lat)) / 10;
				avg_tbl[idx] = nv[19:0];
			end
			push(0, idx, count_tbl[idx], avg_tbl[idx], alive_tbl[idx], 0);
			return;
		end
		chg = 0;
		if (data[6]) begin
			fail_tbl[idx] = 0;
			if (succ_tbl[idx] != STREAK_MAX) succ_tbl[idx]++;
			if (succ_tbl[idx] >= cfg_rise && !alive_tbl[idx]) begin
				alive_tbl[idx] = 1;
				chg = 1;
			end
		end else begin
			succ_tbl[idx] = 0;
			if (fail_tbl[idx] != STREAK_MAX) fail_tbl[idx]++;
			if (fail_tbl[idx] >= cfg_fall && alive_tbl[idx]) begin
				alive_tbl[idx] = 0;
				chg = 1;
			end
		end
		push(0, idx, count_tbl[idx], avg_tbl[idx], alive_tbl[idx], chg);
	endfunction

	function void check_result(logic [47:0] got);
		bit [47:0] want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got[0] !== want[0])
			$display("%0t: found exp %0d got %0d", $time, want[0], got[0]);
		if (got[6:1] !== want[6:1])
			$display("%0t: backend_index exp %0d got %0d", $time, want[6:1], got[6:1]);
		if (got[22:7] !== want[22:7])
			$display("%0t: conn_cnt exp %0d got %0d", $time, want[22:7], got[22:7]);
		if (got[42:23] !== want[42:23])
			$display("%0t: average_ms exp %0d got %0d", $time, want[42:23], got[42:23]);
		if (got[43] !== want[43])
			$display("%0t: alive exp %0d got %0d", $time, want[43], got[43]);
		if (got[44] !== want[44])
			$display("%0t: alive_changed exp %0d got %0d", $time, want[44], got[44]);
		if (got[44:0] !== want[44:0]) errors++;
	endfunction
endclass

module tb_top;
	localparam int LIMIT = 2000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic        cfg_we = 0;
	logic [1:0]  cfg_addr = '0;
	logic [7:0]  cfg_wdata = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;

	backend_scoreboard sb = new();

	least_connections_backend_selector dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("least_connections_backend_selector test failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// present one request; returns at a falling edge
	task automatic send_request(logic [1:0] op, logic [5:0] idx, logic healthy,
			logic ok, logic [19:0] lat);
		s_tuser  <= op;
		s_tdata  <= {4'b0, lat, ok, healthy, idx};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, {4'b0, lat, ok, healthy, idx});
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// hold off until every result is in and the block has settled
	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] addr, logic [7:0] val);
		cfg_we    <= 1;
		cfg_addr  <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(addr, val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_request();
		logic [1:0]  op;
		logic [5:0]  idx;
		logic [19:0] lat;
		int          n, r;
		n = sb.entries();
		r = $urandom_range(0, 99);
		op = (r < 35) ? OP_PICK : (r < 65) ? OP_DONE : (r < 95) ? OP_HEALTH : OP_RSVD;
		if ($urandom_range(0, 99) < 85 && n > 0) idx = 6'($urandom_range(0, n - 1));
		else idx = 6'($urandom_range(0, 63));
		lat = ($urandom_range(0, 1)) ? 20'($urandom_range(0, 1000)) : 20'($urandom);
		send_request(op, idx, $urandom_range(0, 99) < 70, 1'($urandom_range(0, 1)), lat);
	endtask

	int phase_count [6] = '{64, 1, 127, 0, 8, 5};
	int phase_rise  [6] = '{1, 255, 3, 1, 2, 1};
	int phase_fall  [6] = '{1, 255, 1, 2, 4, 2};

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// no backend alive yet
		send_request(OP_PICK, 0, 0, 0, 0);
		send_request(OP_HEALTH, 0, 0, 0, 0);
		send_request(OP_HEALTH, 0, 1, 0, 0);
		send_request(OP_HEALTH, 0, 1, 0, 0);
		send_request(OP_HEALTH, 1, 1, 0, 0);
		send_request(OP_HEALTH, 1, 1, 0, 0);
		// ties between the two alive entries
		send_request(OP_PICK, 0, 0, 0, 0);
		send_request(OP_PICK, 0, 0, 0, 0);
		send_request(OP_PICK, 0, 0, 0, 0);
		send_request(OP_DONE, 0, 0, 1, 20'hFFFFF);
		send_request(OP_DONE, 0, 0, 1, 0);
		send_request(OP_DONE, 0, 0, 1, 20'd5);
		send_request(OP_DONE, 1, 0, 0, 20'd77);
		send_request(OP_DONE, 1, 0, 0, 20'd77);
		send_request(OP_RSVD, 6'd63, 1, 1, 20'hFFFFF);
		send_request(OP_DONE, 6'd63, 0, 1, 20'd9);
		send_request(OP_HEALTH, 6'd5, 1, 0, 0);
		send_request(OP_HEALTH, 1, 0, 0, 0);
		send_request(OP_HEALTH, 1, 0, 0, 0);
		send_request(OP_PICK, 0, 0, 0, 0);
		// saturate a success streak
		repeat (260) send_request(OP_HEALTH, 2, 1, 0, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_BACKEND_COUNT, 8'(phase_count[ph]));
			write_reg(REG_RISE, 8'(phase_rise[ph]));
			write_reg(REG_FALL, 8'(phase_fall[ph]));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			repeat (55) random_request();
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("least_connections_backend_selector test passed");
		else
			$display("least_connections_backend_selector test failed");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lcbs_pkg.sv
hw/rtl/lcbs_div.sv
hw/rtl/least_connections_backend_selector.sv
bench/tb_top.sv
